@@ rtl/core/ordered_list_insert_delete_core_defines.svh @@
// Assertion macros used by the sequencer of the ordered list core.
// Define NO_ASSERTIONS to compile them away.
`ifndef ORDERED_LIST_INSERT_DELETE_CORE_DEFINES_SVH
`define ORDERED_LIST_INSERT_DELETE_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Whenever cond holds, prop must hold in the same cycle.
`define OLDL_ASSERT_SAME(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Whenever cond holds, prop must hold in the next cycle.
`define OLDL_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`else

`define OLDL_ASSERT_SAME(label, clk, rst, cond, prop, msg)
`define OLDL_ASSERT_NEXT(label, clk, rst, cond, prop, msg)

`endif

`endif

@@ rtl/core/oldl_pkg.sv @@
package oldl_pkg;

   // Default sizes of the list.
   localparam int CAPACITY_DEFAULT   = 64;
   localparam int VALUE_BITS_DEFAULT = 32;

   // Field widths of the item ports.
   localparam int CMD_BITS     = 2;
   localparam int ELEMENT_BITS = 32;
   localparam int PLACE_BITS   = 6;
   localparam int STATUS_BITS  = 2;

   // Command codes.
   localparam logic [CMD_BITS-1:0] CMD_PUSH_FRONT = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_PUSH_BACK  = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_REMOVE     = 2'd2;

   // Status codes.
   localparam logic [STATUS_BITS-1:0] STATUS_DONE     = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL     = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_BAD_POS  = 2'd2;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_DUMP = 3'b100
   } state_type;

   // Per-cycle command to every cell of the chain; at most one flag is set.
   typedef struct packed {
      logic push_front;
      logic push_back;
      logic remove;
      logic rotate;
   } cell_ctrl_type;

endpackage

@@ rtl/core/oldl_cell.sv @@
module oldl_cell #(
   parameter int INDEX      = 0,
   parameter int CAPACITY   = oldl_pkg::CAPACITY_DEFAULT,
   parameter int VALUE_BITS = oldl_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                          clock,
   input  oldl_pkg::cell_ctrl_type       ctrl,
   input  logic [VALUE_BITS-1:0]         ins_value,
   input  logic [$clog2(CAPACITY+1)-1:0] pos,
   input  logic [$clog2(CAPACITY+1)-1:0] count,
   input  logic [VALUE_BITS-1:0]         left_data,
   input  logic [VALUE_BITS-1:0]         right_data,
   input  logic [VALUE_BITS-1:0]         head_data,
   output logic [VALUE_BITS-1:0]         data
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] MY_IDX   = CW'(INDEX);
   localparam logic [CW-1:0] NEXT_IDX = CW'(INDEX + 1);

   logic [VALUE_BITS-1:0] data_ff;
   logic [VALUE_BITS-1:0] data_in;

   // Select the new content of this place from the command in flight.
   always_comb begin
      data_in = data_ff;
      if (ctrl.push_front) begin
         data_in = left_data;
      end else if (ctrl.push_back) begin
         if (MY_IDX == count) begin
            data_in = ins_value;
         end
      end else if (ctrl.remove) begin
         if ((MY_IDX >= pos) && (NEXT_IDX < count)) begin
            data_in = right_data;
         end
      end else if (ctrl.rotate) begin
         if (NEXT_IDX < count) begin
            data_in = right_data;
         end else if (NEXT_IDX == count) begin
            data_in = head_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

@@ rtl/core/oldl_seq.sv @@
`include "ordered_list_insert_delete_core_defines.svh"

module oldl_seq #(
   parameter int CAPACITY   = oldl_pkg::CAPACITY_DEFAULT,
   parameter int VALUE_BITS = oldl_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [oldl_pkg::CMD_BITS-1:0]          req_command,
   input  logic signed [oldl_pkg::ELEMENT_BITS-1:0] req_value,
   input  logic [oldl_pkg::PLACE_BITS-1:0]        req_position,
   output oldl_pkg::cell_ctrl_type                ctrl,
   output logic [VALUE_BITS-1:0]                  ins_value,
   output logic [$clog2(CAPACITY+1)-1:0]          pos,
   output logic [$clog2(CAPACITY+1)-1:0]          count,
   input  logic [VALUE_BITS-1:0]                  head_data,
   output logic                                   rsp_strobe,
   output logic signed [oldl_pkg::ELEMENT_BITS-1:0] rsp_element,
   output logic [oldl_pkg::PLACE_BITS-1:0]        rsp_place,
   output logic                                   rsp_list_empty,
   output logic                                   rsp_last,
   output logic [oldl_pkg::STATUS_BITS-1:0]       rsp_status
);

   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > oldl_pkg::PLACE_BITS) ? CW : oldl_pkg::PLACE_BITS;
   localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

   oldl_pkg::state_type state_ff, state_in;

   logic [oldl_pkg::CMD_BITS-1:0]    cmd_ff;
   logic [VALUE_BITS-1:0]            val_ff, val_in;
   logic [oldl_pkg::PLACE_BITS-1:0]  pos_ff;
   logic [CW-1:0]                    count_ff, count_in;
   logic [CW-1:0]                    idx_ff, idx_in;
   logic [oldl_pkg::STATUS_BITS-1:0] status_ff, status_in;

   logic                                    strobe_ff, strobe_in;
   logic signed [oldl_pkg::ELEMENT_BITS-1:0] element_ff, element_in;
   logic [oldl_pkg::PLACE_BITS-1:0]         place_ff, place_in;
   logic                                    empty_ff, empty_in;
   logic                                    last_ff, last_in;

   logic                       accept;
   logic signed [63:0]         req_wide;
   logic signed [63:0]         head_wide;
   logic [CMPW-1:0]            pos_cmp;
   logic [CMPW-1:0]            count_cmp;
   logic [CW-1:0]              idx_next;

   assign accept = start && (state_ff == oldl_pkg::ST_IDLE);
   assign busy   = (state_ff != oldl_pkg::ST_IDLE);

   // Incoming value is sign-extended and kept in VALUE_BITS bits.
   assign req_wide  = 64'(req_value);
   assign val_in    = accept ? req_wide[VALUE_BITS-1:0] : val_ff;
   assign head_wide = 64'($signed(head_data));

   assign pos_cmp   = CMPW'(pos_ff);
   assign count_cmp = CMPW'(count_ff);
   assign idx_next  = idx_ff + CW'(1);

   // Sequencer: apply the command in the cells, then stream the list out.
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      status_in  = status_ff;
      ctrl       = '0;
      strobe_in  = 1'b0;
      element_in = element_ff;
      place_in   = place_ff;
      empty_in   = empty_ff;
      last_in    = last_ff;
      case (state_ff)
         oldl_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = oldl_pkg::ST_EXEC;
            end
         end
         oldl_pkg::ST_EXEC: begin
            idx_in    = '0;
            status_in = oldl_pkg::STATUS_DONE;
            state_in  = oldl_pkg::ST_DUMP;
            case (cmd_ff)
               oldl_pkg::CMD_PUSH_FRONT, oldl_pkg::CMD_PUSH_BACK: begin
                  if (count_ff >= CAP_COUNT) begin
                     status_in = oldl_pkg::STATUS_FULL;
                  end else begin
                     ctrl.push_front = (cmd_ff == oldl_pkg::CMD_PUSH_FRONT);
                     ctrl.push_back  = (cmd_ff == oldl_pkg::CMD_PUSH_BACK);
                     count_in        = count_ff + CW'(1);
                  end
               end
               oldl_pkg::CMD_REMOVE: begin
                  if (pos_cmp >= count_cmp) begin
                     status_in = oldl_pkg::STATUS_BAD_POS;
                  end else begin
                     ctrl.remove = 1'b1;
                     count_in    = count_ff - CW'(1);
                  end
               end
               default: begin
               end
            endcase
         end
         oldl_pkg::ST_DUMP: begin
            strobe_in = 1'b1;
            if (count_ff == '0) begin
               element_in = '0;
               place_in   = '0;
               empty_in   = 1'b1;
               last_in    = 1'b1;
               state_in   = oldl_pkg::ST_IDLE;
            end else begin
               ctrl.rotate = 1'b1;
               element_in  = head_wide[oldl_pkg::ELEMENT_BITS-1:0];
               place_in    = oldl_pkg::PLACE_BITS'(idx_ff);
               empty_in    = 1'b0;
               last_in     = (idx_next == count_ff);
               idx_in      = idx_next;
               if (idx_next == count_ff) begin
                  state_in = oldl_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = oldl_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= oldl_pkg::ST_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_command;
         pos_ff <= req_position;
      end
      val_ff     <= val_in;
      idx_ff     <= idx_in;
      status_ff  <= status_in;
      element_ff <= element_in;
      place_ff   <= place_in;
      empty_ff   <= empty_in;
      last_ff    <= last_in;
   end

   assign ins_value      = val_ff;
   assign pos            = CW'(pos_ff);
   assign count          = count_ff;
   assign rsp_strobe     = strobe_ff;
   assign rsp_element    = element_ff;
   assign rsp_place      = place_ff;
   assign rsp_list_empty = empty_ff;
   assign rsp_last       = last_ff;
   assign rsp_status     = status_ff;

   // Checks on the sequencer.
   `OLDL_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CAP_COUNT, "count overflow")
   `OLDL_ASSERT_NEXT(a_accept_exec, clock, reset, accept, state_ff == oldl_pkg::ST_EXEC, "no exec")
   `OLDL_ASSERT_SAME(a_empty_last, clock, reset, rsp_strobe && rsp_list_empty, rsp_last && (rsp_place == '0), "empty not last")
   `OLDL_ASSERT_NEXT(a_empty_done, clock, reset, (state_ff == oldl_pkg::ST_DUMP) && (count_ff == '0), state_ff == oldl_pkg::ST_IDLE, "empty dump continues")

endmodule

@@ rtl/core/ordered_list_insert_delete_core.sv @@
// Ordered list core: keeps up to CAPACITY signed values in a chain of cells,
// head first, one value per cell.
// Command channel: an item (req_command, req_value, req_position) is taken
// at a clock edge with start high and busy low. Commands insert at the head,
// append at the tail or delete at a zero-based position.
// Result channel: after each command the whole list streams out head to
// tail, one item per cycle on rsp_strobe, with rsp_last on the final one.
// An empty list gives one item with rsp_list_empty set. rsp_status carries
// the outcome in every item of the stream.
// After the accepting edge the sequencer applies the command in the cells in
// its exec state, then streams the list from its dump state through the
// result registers. The block stays busy and takes no new command until
// the final item is registered, since the chain rotates one place per cycle
// to bring each element to the head cell.
// Reset clears the element count and the sequencer; cell contents are not
// cleared. The receiver cannot stall: each result is valid for one cycle.
module ordered_list_insert_delete_core #(
   parameter int CAPACITY   = oldl_pkg::CAPACITY_DEFAULT,
   parameter int VALUE_BITS = oldl_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   output logic                                     busy,
   input  logic [oldl_pkg::CMD_BITS-1:0]            req_command,
   input  logic signed [oldl_pkg::ELEMENT_BITS-1:0] req_value,
   input  logic [oldl_pkg::PLACE_BITS-1:0]          req_position,
   output logic                                     rsp_strobe,
   output logic signed [oldl_pkg::ELEMENT_BITS-1:0] rsp_element,
   output logic [oldl_pkg::PLACE_BITS-1:0]          rsp_place,
   output logic                                     rsp_list_empty,
   output logic                                     rsp_last,
   output logic [oldl_pkg::STATUS_BITS-1:0]         rsp_status
);

   localparam int CW = $clog2(CAPACITY + 1);

   oldl_pkg::cell_ctrl_type ctrl;
   logic [VALUE_BITS-1:0]   ins_value;
   logic [CW-1:0]           pos;
   logic [CW-1:0]           count;
   logic [VALUE_BITS-1:0]   cell_data [CAPACITY];

   // Command sequencer and result register.
   oldl_seq #(
      .CAPACITY   (CAPACITY),
      .VALUE_BITS (VALUE_BITS)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_command    (req_command),
      .req_value      (req_value),
      .req_position   (req_position),
      .ctrl           (ctrl),
      .ins_value      (ins_value),
      .pos            (pos),
      .count          (count),
      .head_data      (cell_data[0]),
      .rsp_strobe     (rsp_strobe),
      .rsp_element    (rsp_element),
      .rsp_place      (rsp_place),
      .rsp_list_empty (rsp_list_empty),
      .rsp_last       (rsp_last),
      .rsp_status     (rsp_status)
   );

   // Chain of cells; the head cell takes the new value on a head insert.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [VALUE_BITS-1:0] left_w;
      logic [VALUE_BITS-1:0] right_w;

      if (i == 0) begin : g_head
         assign left_w = ins_value;
      end else begin : g_body
         assign left_w = cell_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_w = cell_data[i];
      end else begin : g_mid
         assign right_w = cell_data[i+1];
      end

      oldl_cell #(
         .INDEX      (i),
         .CAPACITY   (CAPACITY),
         .VALUE_BITS (VALUE_BITS)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .ins_value  (ins_value),
         .pos        (pos),
         .count      (count),
         .left_data  (left_w),
         .right_data (right_w),
         .head_data  (cell_data[0]),
         .data       (cell_data[i])
      );
   end

endmodule
